[rtl/pfrm_pkg.sv]
// Shared types and constants of the per-flow rate meter.
// Depends on nothing; every other file in rtl uses it.
package pfrm_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] MIN_IPV4_LEN   = 16'd34;
    localparam logic [15:0] LEN_MAX        = 16'hFFFF;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [29:0] NS_PER_S       = 30'd1000000000;
    localparam logic [31:0] HASH_MULT      = 32'h045D9F3B;
    localparam int          RATE_W         = 46;

    localparam logic [2:0] ST_NOT_PARSED = 3'd0;
    localparam logic [2:0] ST_UPDATED    = 3'd1;
    localparam logic [2:0] ST_SAME_TIME  = 3'd2;
    localparam logic [2:0] ST_INSERTED   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [63:0] arrival_time_ns;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       source_address;
        logic [31:0]       destination_address;
        logic [15:0]       source_port;
        logic [15:0]       destination_port;
        logic [7:0]        protocol_number;
        logic [15:0]       frame_length;
        logic [63:0]       flow_total_bytes;
        logic [RATE_W-1:0] flow_rate;
    } out_item_t;

    // One parsed frame, handed from the parser to the table engine.
    typedef struct packed {
        logic        parsed;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] len;
        logic [63:0] stamp;
    } frame_desc_t;

    typedef struct packed {
        logic              valid;
        logic [63:0]       addrs;
        logic [39:0]       ports_proto;
        logic [63:0]       last_time;
        logic [63:0]       byte_total;
        logic [RATE_W-1:0] rate;
    } flow_entry_t;

endpackage

[rtl/pfrm_parser.sv]
// Byte-stream front end: counts frame bytes, captures header fields on the fly
// and emits one frame descriptor per frame. Depends on pfrm_pkg.
module pfrm_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  pfrm_pkg::in_item_t    in_item,
    output logic                  in_ready,
    input  logic                  desc_ready,
    input  logic                  enable,
    output logic                  desc_push,
    output pfrm_pkg::frame_desc_t desc
);

    logic [15:0] count_reg, count_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] pos;
    logic [15:0] l4;
    logic [15:0] len;
    logic [15:0] need;
    logic        accept;
    logic [7:0]  b;

    assign in_ready  = desc_ready && enable;
    assign accept    = in_valid && in_ready;
    assign desc_push = accept && in_item.frame_end;
    assign pos       = count_reg;
    assign b         = in_item.frame_byte;

    always_comb begin
        stamp_next = stamp_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        count_next = count_reg;
        if (accept) begin
            if (pos == 16'd0) begin
                stamp_next = in_item.arrival_time_ns;
            end
            if (pos == 16'd12 || pos == 16'd13) begin
                etype_next = {etype_reg[7:0], b};
            end
            if (pos == 16'd14) begin
                ihl_next = b[3:0];
            end
            if (pos == 16'd23) begin
                proto_next = b;
            end
            if (pos >= 16'd26 && pos <= 16'd29) begin
                src_next = {src_reg[23:0], b};
            end
            if (pos >= 16'd30 && pos <= 16'd33) begin
                dst_next = {dst_reg[23:0], b};
            end
        end
        // The port offset follows the IHL nibble, which may arrive this very cycle.
        l4 = 16'd14 + {10'd0, ihl_next, 2'b00};
        if (accept) begin
            if (pos == l4 || pos == l4 + 16'd1) begin
                sport_next = {sport_reg[7:0], b};
            end
            if (pos == l4 + 16'd2 || pos == l4 + 16'd3) begin
                dport_next = {dport_reg[7:0], b};
            end
            if (in_item.frame_end) begin
                count_next = 16'd0;
            end else if (count_reg != pfrm_pkg::LEN_MAX) begin
                count_next = count_reg + 16'd1;
            end
        end
        len  = (count_reg == pfrm_pkg::LEN_MAX) ? count_reg : count_reg + 16'd1;
        need = (proto_next == pfrm_pkg::PROTO_TCP) ? l4 + 16'd20 : l4 + 16'd8;

        desc.parsed = (len >= pfrm_pkg::MIN_IPV4_LEN)
                   && (etype_next == pfrm_pkg::ETHERTYPE_IPV4)
                   && (proto_next == pfrm_pkg::PROTO_TCP
                       || proto_next == pfrm_pkg::PROTO_UDP)
                   && (len >= need);
        desc.src   = src_next;
        desc.dst   = dst_next;
        desc.sport = sport_next;
        desc.dport = dport_next;
        desc.proto = proto_next;
        desc.len   = len;
        desc.stamp = stamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 16'd0;
            stamp_reg <= 64'd0;
        end else begin
            count_reg <= count_next;
            stamp_reg <= stamp_next;
        end
        etype_reg <= etype_next;
        ihl_reg   <= ihl_next;
        proto_reg <= proto_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        sport_reg <= sport_next;
        dport_reg <= dport_next;
    end

endmodule

[rtl/pfrm_queue.sv]
// Two-entry descriptor queue between the parser and the table engine.
// Depends on pfrm_pkg.
module pfrm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  pfrm_pkg::frame_desc_t push_desc,
    output logic                  push_ready,
    input  logic                  pop,
    output logic                  head_valid,
    output pfrm_pkg::frame_desc_t head
);

    pfrm_pkg::frame_desc_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/pfrm_table.sv]
// Flow table engine: hashes the 5-tuple, walks the bucket ways, divides for the
// rate and drives the result register. Depends on pfrm_pkg.
module pfrm_table #(
    parameter int FLOW_ENTRIES = 1024,
    parameter int BUCKET_WAYS  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  pfrm_pkg::frame_desc_t q_head,
    output logic                  q_pop,
    output logic                  ready_for_frames,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfrm_pkg::out_item_t   m_item
);

    localparam int   AW      = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int   BUCKETS = FLOW_ENTRIES / BUCKET_WAYS;
    localparam int   BW      = $clog2(BUCKETS) + 1;
    localparam int   WW      = $clog2(BUCKET_WAYS + 1);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(FLOW_ENTRIES - 1);
    localparam logic [WW-1:0] LAST_WAY   = WW'(BUCKET_WAYS - 1);
    localparam int   RW = pfrm_pkg::RATE_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH_A, S_HASH_B, S_HASH_C, S_MOD_A, S_MOD_B, S_MOD_C,
        S_READ, S_CHECK, S_DIV, S_WRITE, S_MISS, S_OUT
    } state_t;

    state_t                state_reg;
    pfrm_pkg::frame_desc_t desc_reg;
    pfrm_pkg::out_item_t   out_reg;
    logic                  m_valid_reg;
    logic [AW-1:0]         clr_reg;
    logic [31:0]           h_reg;
    logic [64:0]           prod_reg;
    logic [BW:0]           r_reg;
    logic [AW-1:0]         base_reg;
    logic [WW-1:0]         way_reg;
    logic                  have_free_reg;
    logic [AW-1:0]         free_addr_reg;
    logic [AW-1:0]         hit_addr_reg;
    pfrm_pkg::flow_entry_t hit_reg;
    logic [RW-1:0]         num_reg;
    logic [63:0]           den_reg;
    logic [63:0]           rem_reg;
    logic [5:0]            div_cnt_reg;

    pfrm_pkg::flow_entry_t mem [FLOW_ENTRIES];
    pfrm_pkg::flow_entry_t rd_data_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    pfrm_pkg::flow_entry_t mem_wd;
    logic [AW-1:0]         mem_ra;
    logic [31:0]           h0;
    logic [63:0]           key_addrs;
    logic [39:0]           key_pp;
    logic                  match;
    logic [63:0]           delta;
    logic [64:0]           trial;
    logic [BW:0]           r_fold;
    logic [63:0]           qb;

    assign key_addrs = {desc_reg.src, desc_reg.dst};
    assign key_pp    = {desc_reg.sport, desc_reg.dport, desc_reg.proto};
    assign h0 = desc_reg.src ^ {desc_reg.dst[18:0], desc_reg.dst[31:19]}
              ^ {desc_reg.sport, desc_reg.dport} ^ {24'd0, desc_reg.proto};
    assign mem_ra = base_reg + AW'(way_reg);
    assign match  = rd_data_reg.valid && (rd_data_reg.addrs == key_addrs)
                 && (rd_data_reg.ports_proto == key_pp);
    assign delta  = desc_reg.stamp - rd_data_reg.last_time;
    assign trial  = {rem_reg, num_reg[RW-1]};
    assign qb     = 64'(prod_reg[64:32]) * 64'(BUCKETS);
    assign r_fold = (r_reg >= (BW + 1)'(BUCKETS)) ? r_reg - (BW + 1)'(BUCKETS) : r_reg;

    assign q_pop            = (state_reg == S_IDLE) && q_valid;
    assign ready_for_frames = (state_reg != S_CLEAR);
    assign m_valid          = m_valid_reg;
    assign m_item           = out_reg;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_WRITE: begin
                mem_we            = 1'b1;
                mem_wa            = hit_addr_reg;
                mem_wd            = hit_reg;
                mem_wd.rate       = num_reg;
                mem_wd.byte_total = hit_reg.byte_total + 64'(desc_reg.len);
                mem_wd.last_time  = desc_reg.stamp;
            end
            S_MISS: begin
                mem_we             = have_free_reg;
                mem_wa             = free_addr_reg;
                mem_wd.valid       = 1'b1;
                mem_wd.addrs       = key_addrs;
                mem_wd.ports_proto = key_pp;
                mem_wd.last_time   = desc_reg.stamp;
                mem_wd.byte_total  = 64'(desc_reg.len);
                mem_wd.rate        = '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == LAST_ENTRY) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        desc_reg <= q_head;
                        if (!q_head.parsed) begin
                            out_reg     <= {pfrm_pkg::ST_NOT_PARSED, 104'd0, q_head.len,
                                            64'd0, RW'(0)};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_HASH_A;
                        end
                    end
                end
                S_HASH_A: begin
                    h_reg     <= h0 ^ (h0 >> 16);
                    state_reg <= S_HASH_B;
                end
                S_HASH_B: begin
                    h_reg     <= h_reg * pfrm_pkg::HASH_MULT;
                    state_reg <= S_HASH_C;
                end
                S_HASH_C: begin
                    h_reg     <= h_reg ^ (h_reg >> 16);
                    state_reg <= S_MOD_A;
                end
                S_MOD_A: begin
                    prod_reg  <= 65'(h_reg) * 65'(RECIP);
                    state_reg <= S_MOD_B;
                end
                S_MOD_B: begin
                    r_reg     <= (BW + 1)'(64'(h_reg) - qb);
                    state_reg <= S_MOD_C;
                end
                S_MOD_C: begin
                    base_reg      <= AW'(32'(r_fold) * 32'(BUCKET_WAYS));
                    way_reg       <= '0;
                    have_free_reg <= 1'b0;
                    state_reg     <= S_READ;
                end
                S_READ: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (match) begin
                        out_reg.source_address      <= desc_reg.src;
                        out_reg.destination_address <= desc_reg.dst;
                        out_reg.source_port         <= desc_reg.sport;
                        out_reg.destination_port    <= desc_reg.dport;
                        out_reg.protocol_number     <= desc_reg.proto;
                        out_reg.frame_length        <= desc_reg.len;
                        if (delta == 64'd0) begin
                            out_reg.status           <= pfrm_pkg::ST_SAME_TIME;
                            out_reg.flow_total_bytes <= rd_data_reg.byte_total;
                            out_reg.flow_rate        <= rd_data_reg.rate;
                            m_valid_reg              <= 1'b1;
                            state_reg                <= S_OUT;
                        end else begin
                            num_reg      <= RW'(desc_reg.len) * RW'(pfrm_pkg::NS_PER_S);
                            den_reg      <= delta;
                            rem_reg      <= 64'd0;
                            div_cnt_reg  <= 6'(RW - 1);
                            hit_reg      <= rd_data_reg;
                            hit_addr_reg <= mem_ra;
                            state_reg    <= S_DIV;
                        end
                    end else begin
                        if (!rd_data_reg.valid && !have_free_reg) begin
                            have_free_reg <= 1'b1;
                            free_addr_reg <= mem_ra;
                        end
                        if (way_reg == LAST_WAY) begin
                            state_reg <= S_MISS;
                        end else begin
                            way_reg   <= way_reg + WW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle; the quotient
                    // shifts into the numerator register as its bits are consumed.
                    if (trial >= {1'b0, den_reg}) begin
                        rem_reg <= 64'(trial - {1'b0, den_reg});
                        num_reg <= {num_reg[RW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[63:0];
                        num_reg <= {num_reg[RW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd0) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    out_reg.status           <= pfrm_pkg::ST_UPDATED;
                    out_reg.flow_total_bytes <= mem_wd.byte_total;
                    out_reg.flow_rate        <= num_reg;
                    m_valid_reg              <= 1'b1;
                    state_reg                <= S_OUT;
                end
                S_MISS: begin
                    out_reg.source_address      <= desc_reg.src;
                    out_reg.destination_address <= desc_reg.dst;
                    out_reg.source_port         <= desc_reg.sport;
                    out_reg.destination_port    <= desc_reg.dport;
                    out_reg.protocol_number     <= desc_reg.proto;
                    out_reg.frame_length        <= desc_reg.len;
                    out_reg.flow_rate           <= '0;
                    if (have_free_reg) begin
                        out_reg.status           <= pfrm_pkg::ST_INSERTED;
                        out_reg.flow_total_bytes <= 64'(desc_reg.len);
                    end else begin
                        out_reg.status           <= pfrm_pkg::ST_TABLE_FULL;
                        out_reg.flow_total_bytes <= 64'd0;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg == (state_reg == S_OUT))
        else $error("result valid disagrees with the output state");

    a_unparsed_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_head.parsed) |=> (m_valid_reg
            && out_reg.status == pfrm_pkg::ST_NOT_PARSED))
        else $error("unparsed frame did not report at once");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_cnt_reg == 6'd0) |=> (state_reg == S_WRITE))
        else $error("division did not hand over to the write-back");

    a_no_write_while_held: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !m_valid_reg)
        else $error("table written while a result is held");
`endif

endmodule

[rtl/per_flow_rate_meter.sv]
// Top level of the per-flow rate meter.
// Depends on pfrm_pkg, pfrm_parser, pfrm_queue and pfrm_table.
//
// Usage. The s_ channel carries one frame byte per item with its arrival time;
// the item with frame_end set closes the frame. The m_ channel carries exactly
// one result item per frame: its parse status, 5-tuple, length and the flow's
// byte total and rate after the frame.
// Throughput. Bytes are taken one per cycle while s_ready is high; it is low
// during the table clear and while the descriptor queue is full. Each frame
// then occupies the table engine for the hash, the bucket walk and, when a hit
// needs it, the bit-serial rate division; unparsed frames skip all of these.
// A two-item queue of frame descriptors lets the byte stream run on while
// the engine works, so short frames only back-pressure s_ready once two
// frames are waiting.
// Reset. After aresetn is released the engine clears all FLOW_ENTRIES table
// rows, one per cycle; s_ready stays low until the clear is done.
// Stalls. A held result waits in the output register until m_ready; the engine
// stops meanwhile and the front end keeps taking bytes until the queue fills.
module per_flow_rate_meter #(
    parameter int FLOW_ENTRIES = 1024,
    parameter int BUCKET_WAYS  = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfrm_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pfrm_pkg::out_item_t m_item
);

    pfrm_pkg::frame_desc_t desc;
    pfrm_pkg::frame_desc_t head;
    logic                  desc_push;
    logic                  push_ready;
    logic                  head_valid;
    logic                  pop;
    logic                  engine_ready;

    // The front end counts bytes and captures the header fields as they pass.
    pfrm_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_item    (s_item),
        .in_ready   (s_ready),
        .desc_ready (push_ready),
        .enable     (engine_ready),
        .desc_push  (desc_push),
        .desc       (desc)
    );

    // The queue decouples byte intake from the per-frame table work.
    pfrm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (desc_push),
        .push_desc  (desc),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end owns the flow table memory and the result register.
    pfrm_table #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .BUCKET_WAYS  (BUCKET_WAYS)
    ) u_table (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (head_valid),
        .q_head           (head),
        .q_pop            (pop),
        .ready_for_frames (engine_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item           (m_item)
    );

endmodule

[verif/testbench.sv]
// Self-checking testbench of per_flow_rate_meter: drives frame bytes, predicts every
// per-frame result with a local flow-table model and checks each one. Depends on pfrm_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 1024;
    localparam int WAYS       = 4;
    localparam int HDR_BYTES  = 78;
    localparam int IDLE_LIMIT = 5000;

    // Frame time selection for the directed frames.
    typedef enum int {T_STEP, T_SAME, T_ZERO, T_ONES, T_PLUS1} tsel_t;

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_t;

    typedef struct {
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        int          len;
        int          flow;
        tsel_t       tsel;
        bit          typed;
        logic [2:0]  st;
    } dir_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pfrm_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pfrm_pkg::out_item_t m_item;

    per_flow_rate_meter #(.FLOW_ENTRIES(ENTRIES), .BUCKET_WAYS(WAYS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #4 aclk = ~aclk;

    // Local copy of the meter's state.
    logic [7:0]                  hdr [HDR_BYTES];
    logic [15:0]                 byte_cnt = '0;
    logic [63:0]                 first_time = '0;
    bit                          tbl_valid [ENTRIES];
    logic [63:0]                 tbl_addrs [ENTRIES];
    logic [39:0]                 tbl_pp    [ENTRIES];
    logic [63:0]                 tbl_last  [ENTRIES];
    logic [63:0]                 tbl_total [ENTRIES];
    logic [pfrm_pkg::RATE_W-1:0] tbl_rate  [ENTRIES];

    pfrm_pkg::out_item_t expected_results [$];
    bit          failed = 1'b0;
    int          idle_cycles = 0;
    flow_t       flows [9];
    logic [63:0] tnow = 64'd1000;

    function automatic int flow_bucket(logic [31:0] src, logic [31:0] dst,
                                       logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
        logic [31:0] h;
        h = src ^ {dst[18:0], dst[31:19]} ^ {sp, dp} ^ {24'd0, pr};
        h = h ^ (h >> 16);
        h = h * pfrm_pkg::HASH_MULT;
        h = h ^ (h >> 16);
        return int'(h % (ENTRIES / WAYS));
    endfunction

    // Advances the local meter by one byte; returns 1 with the frame's result on its
    // last byte.
    function automatic bit meter_step(pfrm_pkg::in_item_t it,
                                      output pfrm_pkg::out_item_t r);
        logic [15:0] len;
        logic [7:0]  pr;
        int          l4, need, base, free_idx, e;
        logic [31:0] src, dst;
        logic [15:0] sp, dp;
        logic [63:0] addr_key, delta;
        logic [39:0] pp_key;
        bit          have_free, done;
        r = '0;
        if (byte_cnt == 0) first_time = it.arrival_time_ns;
        if (byte_cnt < HDR_BYTES) hdr[byte_cnt] = it.frame_byte;
        if (byte_cnt != pfrm_pkg::LEN_MAX) byte_cnt++;
        if (!it.frame_end) return 1'b0;
        len = byte_cnt;
        byte_cnt = '0;
        r.frame_length = len;
        r.status = pfrm_pkg::ST_NOT_PARSED;
        if (len < pfrm_pkg::MIN_IPV4_LEN || {hdr[12], hdr[13]} != pfrm_pkg::ETHERTYPE_IPV4)
            return 1'b1;
        pr = hdr[23];
        l4 = 14 + 4 * int'(hdr[14][3:0]);
        if (pr == pfrm_pkg::PROTO_TCP) need = l4 + 20;
        else if (pr == pfrm_pkg::PROTO_UDP) need = l4 + 8;
        else return 1'b1;
        if (int'(len) < need) return 1'b1;
        src = {hdr[26], hdr[27], hdr[28], hdr[29]};
        dst = {hdr[30], hdr[31], hdr[32], hdr[33]};
        sp  = {hdr[l4], hdr[l4+1]};
        dp  = {hdr[l4+2], hdr[l4+3]};
        addr_key = {src, dst};
        pp_key = {sp, dp, pr};
        base = flow_bucket(src, dst, sp, dp, pr) * WAYS;
        r.status = pfrm_pkg::ST_TABLE_FULL;
        have_free = 1'b0;
        free_idx = 0;
        done = 1'b0;
        for (int w = 0; w < WAYS && !done; w++) begin
            e = base + w;
            if (!tbl_valid[e]) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_idx = e;
                end
            end else if (tbl_addrs[e] == addr_key && tbl_pp[e] == pp_key) begin
                delta = first_time - tbl_last[e];
                if (delta != 0) begin
                    tbl_rate[e] = pfrm_pkg::RATE_W'((64'(len) * 64'd1000000000) / delta);
                    tbl_total[e] += 64'(len);
                    tbl_last[e] = first_time;
                    r.status = pfrm_pkg::ST_UPDATED;
                end else begin
                    r.status = pfrm_pkg::ST_SAME_TIME;
                end
                r.flow_total_bytes = tbl_total[e];
                r.flow_rate = tbl_rate[e];
                done = 1'b1;
            end
        end
        if (r.status == pfrm_pkg::ST_TABLE_FULL && have_free) begin
            tbl_valid[free_idx] = 1'b1;
            tbl_addrs[free_idx] = addr_key;
            tbl_pp[free_idx]    = pp_key;
            tbl_last[free_idx]  = first_time;
            tbl_total[free_idx] = 64'(len);
            tbl_rate[free_idx]  = '0;
            r.status = pfrm_pkg::ST_INSERTED;
            r.flow_total_bytes = 64'(len);
        end
        r.source_address = src;
        r.destination_address = dst;
        r.source_port = sp;
        r.destination_port = dp;
        r.protocol_number = pr;
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Lays out a frame: random filler, then the L4 ports, then the Ethernet and IPv4
    // fields on top, so that a short IHL lets the ports overlap the addresses while the
    // ethertype and protocol stay as asked.
    function automatic void build_frame(flow_t f, int len, logic [15:0] etype,
                                        logic [3:0] ihl, logic [7:0] pr,
                                        ref logic [7:0] fb [$]);
        int l4;
        fb.delete();
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom()));
        l4 = 14 + 4 * int'(ihl);
        if (l4 + 3 < len) begin
            {fb[l4], fb[l4+1], fb[l4+2], fb[l4+3]} = {f.sport, f.dport};
        end
        if (len > 13) {fb[12], fb[13]} = etype;
        if (len > 14) fb[14] = {4'h4, ihl};
        if (len > 23) fb[23] = pr;
        if (len > 29) {fb[26], fb[27], fb[28], fb[29]} = f.src;
        if (len > 33) {fb[30], fb[31], fb[32], fb[33]} = f.dst;
    endfunction

    // Sends one frame byte by byte. Each accepted byte goes through the local meter;
    // a result, when the byte causes one, joins the queue of expected results.
    task automatic send_frame(ref logic [7:0] fb [$], input logic [63:0] stamp,
                              input bit no_gaps, input bit typed, input logic [2:0] st);
        pfrm_pkg::in_item_t  it;
        pfrm_pkg::out_item_t r;
        int                  gap;
        for (int i = 0; i < fb.size(); i++) begin
            it.frame_byte = fb[i];
            it.frame_end = (i == fb.size() - 1);
            it.arrival_time_ns = (i == 0) ? stamp : rand64();
            gap = no_gaps ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_item <= it;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (meter_step(it, r)) begin
                if (typed && r.status !== st) begin
                    $display("%0t: directed frame status expected %0d, predicted %0d",
                             $time, st, r.status);
                    failed = 1'b1;
                end
                expected_results.push_back(r);
            end
        end
    endtask

    function automatic logic [63:0] next_time(tsel_t ts);
        case (ts)
            T_SAME:  return tnow;
            T_ZERO:  return '0;
            T_ONES:  return '1;
            T_PLUS1: return tnow + 64'd1;
            default: return tnow + 64'($urandom_range(1, 200000));
        endcase
    endfunction

    task automatic report(string name, logic [63:0] exp_v, logic [63:0] got_v);
        $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
        failed = 1'b1;
    endtask

    // Result side: random stalls on m_ready, and each accepted item is checked
    // against the oldest expectation.
    initial begin
        int stall;
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        pfrm_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no expectation, got %0h", $time, m_item);
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                if (m_item.status !== e.status) report("status", e.status, m_item.status);
                if (m_item.source_address !== e.source_address)
                    report("source_address", e.source_address, m_item.source_address);
                if (m_item.destination_address !== e.destination_address)
                    report("destination_address", e.destination_address,
                           m_item.destination_address);
                if (m_item.source_port !== e.source_port)
                    report("source_port", e.source_port, m_item.source_port);
                if (m_item.destination_port !== e.destination_port)
                    report("destination_port", e.destination_port, m_item.destination_port);
                if (m_item.protocol_number !== e.protocol_number)
                    report("protocol_number", e.protocol_number, m_item.protocol_number);
                if (m_item.frame_length !== e.frame_length)
                    report("frame_length", e.frame_length, m_item.frame_length);
                if (m_item.flow_total_bytes !== e.flow_total_bytes)
                    report("flow_total_bytes", e.flow_total_bytes, m_item.flow_total_bytes);
                if (m_item.flow_rate !== e.flow_rate)
                    report("flow_rate", e.flow_rate, m_item.flow_rate);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel accepts an item. The table
    // clear after reset, over all ENTRIES rows, stays well inside the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t     rows [$];
        logic [7:0]   fb [$];
        logic [63:0]  stamp;
        int           sent, k, len, ihl, need, tgt;
        bit           burst;
        flow_t        f;
        logic [7:0]   pr;
        logic [15:0]  et;

        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

        // Flow pool: four free flows, then five that share one bucket so that the
        // fifth finds it full.
        for (int i = 0; i < 9; i++) begin
            flows[i].src = $urandom();
            flows[i].dst = $urandom();
            flows[i].sport = 16'($urandom());
            flows[i].dport = 16'($urandom());
            flows[i].proto = $urandom_range(0, 1) ? pfrm_pkg::PROTO_TCP : pfrm_pkg::PROTO_UDP;
        end
        flows[0].src = '1;
        flows[0].sport = '1;
        flows[0].proto = pfrm_pkg::PROTO_UDP;
        flows[1].src = '0;
        flows[1].dport = '0;
        flows[1].proto = pfrm_pkg::PROTO_TCP;
        tgt = flow_bucket(flows[4].src, flows[4].dst, flows[4].sport, flows[4].dport,
                          flows[4].proto);
        for (int i = 5; i < 9; i++) begin
            flows[i] = flows[4];
            do flows[i].src = $urandom();
            while (flow_bucket(flows[i].src, flows[i].dst, flows[i].sport, flows[i].dport,
                               flows[i].proto) != tgt);
        end

        // Directed frames: parse rejections, insert, same time, time wrap both ways,
        // IHL extremes, a full bucket, a frame longer than the header store and a
        // minimal delta.
        rows = '{
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 1,  0, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 33, 0, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h86DD, 4'd5,  pfrm_pkg::PROTO_UDP, 60, 0, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  8'd1,                60, 0, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_TCP, 53, 1, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 41, 0, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 42, 0, T_ZERO, 1, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 42, 0, T_ZERO, 1, pfrm_pkg::ST_SAME_TIME},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 64, 0, T_ONES, 1, pfrm_pkg::ST_UPDATED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 90, 0, T_ZERO, 1, pfrm_pkg::ST_UPDATED},
            '{16'h0800, 4'd15, pfrm_pkg::PROTO_TCP, 94, 1, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd0,  pfrm_pkg::PROTO_TCP, 40, 2, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd4,  pfrm_pkg::PROTO_UDP, 34, 3, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  8'hFF,               60, 3, T_STEP, 1, pfrm_pkg::ST_NOT_PARSED},
            '{16'h0800, 4'd5,  flows[4].proto, 60, 4, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  flows[5].proto, 60, 5, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  flows[6].proto, 60, 6, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  flows[7].proto, 60, 7, T_STEP, 0, pfrm_pkg::ST_INSERTED},
            '{16'h0800, 4'd5,  flows[8].proto, 60, 8, T_STEP, 0, pfrm_pkg::ST_TABLE_FULL},
            '{16'h0800, 4'd5,  flows[5].proto, 70, 5, T_STEP, 0, pfrm_pkg::ST_UPDATED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 100, 0, T_STEP, 0, pfrm_pkg::ST_UPDATED},
            '{16'h0800, 4'd5,  pfrm_pkg::PROTO_UDP, 60, 0, T_PLUS1, 0, pfrm_pkg::ST_UPDATED}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        sent = 0;
        foreach (rows[i]) begin
            stamp = next_time(rows[i].tsel);
            tnow = stamp;
            build_frame(flows[rows[i].flow], rows[i].len, rows[i].etype, rows[i].ihl,
                        rows[i].proto, fb);
            send_frame(fb, stamp, rows[i].len > 1000, rows[i].typed, rows[i].st);
            sent += rows[i].len;
        end

        // Random part: mostly well-formed frames from the flow pool with random
        // content, lengths and times; the rest is noise and broken headers.
        burst = 1'b0;
        while (sent < 1650) begin
            k = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) burst = !burst;
            if (k < 7) begin
                f = flows[$urandom_range(0, 8)];
                ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
                need = 14 + 4 * ihl + ((f.proto == pfrm_pkg::PROTO_TCP) ? 20 : 8);
                if (need < 34) need = 34;
                len = need + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
                                                          : $urandom_range(0, 12));
                pr = f.proto;
                et = pfrm_pkg::ETHERTYPE_IPV4;
            end else begin
                f.src = $urandom();
                f.dst = $urandom();
                f.sport = 16'($urandom());
                f.dport = 16'($urandom());
                ihl = $urandom_range(0, 15);
                len = $urandom_range(1, 60);
                pr = (k == 7) ? 8'($urandom()) : pfrm_pkg::PROTO_TCP;
                et = (k == 8) ? 16'($urandom()) : pfrm_pkg::ETHERTYPE_IPV4;
            end
            case ($urandom_range(0, 9))
                0:       stamp = tnow;
                1:       stamp = rand64();
                default: stamp = tnow + 64'($urandom_range(1, 100000));
            endcase
            tnow = stamp;
            build_frame(f, len, et, 4'(ihl), pr, fb);
            send_frame(fb, stamp, burst, 1'b0, pfrm_pkg::ST_NOT_PARSED);
            sent += len;
        end

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
